[hdl/crc_keyed_table_binary_search_top_defines.svh]
// Assertion macros for the keyed table search block.
// Each macro expects clk and rst to be visible where it is used.
`ifndef CRC_KEYED_TABLE_BINARY_SEARCH_TOP_DEFINES_SVH
`define CRC_KEYED_TABLE_BINARY_SEARCH_TOP_DEFINES_SVH

// Same-cycle implication, ignored while reset is asserted.
`define CKBS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ckbs assertion failed");

// Next-cycle implication, ignored while reset is asserted.
`define CKBS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ckbs assertion failed");

// State right after a reset cycle.
`define CKBS_ASSERT_RESET(label, cons) \
  label: assert property (@(posedge clk) rst |=> (cons)) \
    else $error("ckbs reset check failed");

`endif

[hdl/ckbs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package ckbs_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = IDX_W + 1;
  localparam int STEP_W      = 4;
  localparam int STRIDE_W    = (1 << STEP_W) - 1;
  localparam int PROBE_W     = STRIDE_W + 1;
  localparam int WORD_W      = 32;
  localparam int BYTE_SHIFT  = 2;  // four bytes per word
  localparam int CFG_IDX_W   = 2;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_PRESENT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_STEPS    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_BASE_WORDS = 2'd3;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  typedef struct packed {
    logic              operation;
    logic [IDX_W-1:0]  entry_index;
    logic [WORD_W-1:0] key;
    logic [WORD_W-1:0] entry_offset_words;
    logic [WORD_W-1:0] entry_size;
  } cmd_t;

  typedef struct packed {
    logic              found;
    logic [IDX_W-1:0]  match_index;
    logic [WORD_W-1:0] byte_offset;
    logic [WORD_W-1:0] size_bytes;
  } result_t;

  typedef struct packed {
    logic              table_present;
    logic [CNT_W-1:0]  entry_count;
    logic [STEP_W-1:0] search_steps;
    logic [WORD_W-1:0] data_base_words;
  } cfg_t;

  // Classified transaction held between front and back.
  typedef struct packed {
    logic              lookup;
    logic              miss;    // lookup that cannot hit: no table or zero key
    logic [IDX_W-1:0]  index;
    logic [WORD_W-1:0] key;
    logic [WORD_W-1:0] offset;
    logic [WORD_W-1:0] size;
  } qent_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROBE,
    ST_CMP,
    ST_FETCH,
    ST_DONE
  } back_state_t;

endpackage
`default_nettype wire

[hdl/crc_keyed_table_binary_search_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// Keyed table lookup by power-of-two-step binary search.
// Command channel: a transaction is taken on a clock edge with start high and
// busy low. operation selects an entry load (write key, word offset and size
// into slot entry_index) or a lookup of key.
// Result channel: every lookup gives exactly one result, shown on result for
// one cycle with done high; entry loads give none. The receiver cannot stall,
// so results are never held back and never dropped.
// Config port: cfg_we writes cfg_data into register cfg_index (0 table
// present, 1 entry count, 2 search steps, 3 data base in words); write only
// while no transaction is in flight.
// Search engine: an entry load is written as it leaves the queue. A lookup is
// dequeued, then runs search_steps+1 probes, each a key memory read and then
// a compare, with no read for a probe at or beyond the entry count; a hit then
// reads offset and size and registers the result. A lookup with no table or a
// zero key gets its miss result straight from the dequeue. The engine takes
// the next queue entry only once it is back in idle.
// A two-entry queue sits between command intake and the search engine;
// busy rises only while that queue is full.
// Reset (rst, synchronous) clears the config registers, the queue and the
// engine; table contents are not cleared and must be loaded before use.
module crc_keyed_table_binary_search_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  ckbs_pkg::cmd_t                     cmd,
  output logic                               done,
  output ckbs_pkg::result_t                  result,
  input  logic                               cfg_we,
  input  logic [ckbs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ckbs_pkg::WORD_W-1:0]        cfg_data
);

  ckbs_pkg::cfg_t  cfg;
  ckbs_pkg::qent_t push_data;
  ckbs_pkg::qent_t q_data;
  logic            push;
  logic            pop;
  logic            q_valid;
  logic            q_full;

  // Config registers: take the low bits of the write data for narrow fields.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ckbs_pkg::CFG_TABLE_PRESENT:
          cfg.table_present <= cfg_data[0];
        ckbs_pkg::CFG_ENTRY_COUNT:
          cfg.entry_count <= cfg_data[ckbs_pkg::CNT_W-1:0];
        ckbs_pkg::CFG_SEARCH_STEPS:
          cfg.search_steps <= cfg_data[ckbs_pkg::STEP_W-1:0];
        ckbs_pkg::CFG_DATA_BASE_WORDS:
          cfg.data_base_words <= cfg_data;
        default: cfg <= cfg;
      endcase
    end
  end

  // Intake: classify each transaction and push it into the queue.
  ckbs_front u_front (
    .start         (start),
    .cmd           (cmd),
    .table_present (cfg.table_present),
    .q_full        (q_full),
    .busy          (busy),
    .push          (push),
    .push_data     (push_data)
  );

  // Decouple intake from the search engine.
  ckbs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_full    (q_full),
    .q_data    (q_data)
  );

  // Search engine: table memories, probe sequencer and result register.
  ckbs_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_valid (q_valid),
    .q_data  (q_data),
    .pop     (pop),
    .done    (done),
    .result  (result)
  );

endmodule
`default_nettype wire

[hdl/ckbs_front.sv]
`timescale 1ns / 1ps
`default_nettype none
module ckbs_front (
  input  logic               start,
  input  ckbs_pkg::cmd_t     cmd,
  input  logic               table_present,
  input  logic               q_full,
  output logic               busy,
  output logic               push,
  output ckbs_pkg::qent_t    push_data
);

  assign busy = q_full;
  assign push = start && !q_full;

  // Classify: a lookup with no table or a zero key is a known miss.
  always_comb begin
    push_data.lookup = (cmd.operation == ckbs_pkg::OP_LOOKUP);
    push_data.miss   = !table_present || (cmd.key == '0);
    push_data.index  = cmd.entry_index;
    push_data.key    = cmd.key;
    push_data.offset = cmd.entry_offset_words;
    push_data.size   = cmd.entry_size;
  end

endmodule
`default_nettype wire

[hdl/ckbs_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
module ckbs_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  ckbs_pkg::qent_t push_data,
  input  logic            pop,
  output logic            q_valid,
  output logic            q_full,
  output ckbs_pkg::qent_t q_data
);

  ckbs_pkg::qent_t                     slots [ckbs_pkg::QUEUE_DEPTH];
  logic [ckbs_pkg::QPTR_W-1:0]         wr_ptr;
  logic [ckbs_pkg::QPTR_W-1:0]         rd_ptr;
  logic [ckbs_pkg::QCNT_W-1:0]         count;
  logic                                do_push;
  logic                                do_pop;

  assign q_valid = (count != '0);
  assign q_full  = (count == ckbs_pkg::QCNT_W'(ckbs_pkg::QUEUE_DEPTH));
  assign q_data  = slots[rd_ptr];
  assign do_push = push && !q_full;
  assign do_pop  = pop && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_data;
  end

endmodule
`default_nettype wire

[hdl/ckbs_back.sv]
`timescale 1ns / 1ps
`default_nettype none
module ckbs_back (
  input  logic              clk,
  input  logic              rst,
  input  ckbs_pkg::cfg_t    cfg,
  input  logic              q_valid,
  input  ckbs_pkg::qent_t   q_data,
  output logic              pop,
  output logic              done,
  output ckbs_pkg::result_t result
);

  localparam int IDX_W    = ckbs_pkg::IDX_W;
  localparam int CNT_W    = ckbs_pkg::CNT_W;
  localparam int STEP_W   = ckbs_pkg::STEP_W;
  localparam int STRIDE_W = ckbs_pkg::STRIDE_W;
  localparam int PROBE_W  = ckbs_pkg::PROBE_W;
  localparam int WORD_W   = ckbs_pkg::WORD_W;

  ckbs_pkg::back_state_t state;
  ckbs_pkg::back_state_t state_next;

  logic [WORD_W-1:0]   keys      [ckbs_pkg::TABLE_DEPTH];
  logic [2*WORD_W-1:0] entry_data [ckbs_pkg::TABLE_DEPTH];

  logic [IDX_W-1:0]    pos;
  logic [STEP_W-1:0]   sh;
  logic                hit;
  logic [IDX_W-1:0]    hit_idx;
  logic [IDX_W-1:0]    probe_idx;
  logic [WORD_W-1:0]   skey;
  logic [WORD_W-1:0]   rd_key;
  logic [2*WORD_W-1:0] rd_data;

  logic [CNT_W-1:0]    limit;
  logic [STRIDE_W-1:0] stride;
  logic [PROBE_W-1:0]  probe;
  logic                in_range;
  logic                mem_wr;
  logic                key_rd;
  logic                data_rd;
  logic [WORD_W-1:0]   word_sum;

  assign limit = (cfg.entry_count > CNT_W'(ckbs_pkg::TABLE_DEPTH)) ?
                 CNT_W'(ckbs_pkg::TABLE_DEPTH) : cfg.entry_count;
  assign stride   = (sh == '0) ? '0 : (STRIDE_W'(1) << (sh - 1'b1));
  assign probe    = PROBE_W'(pos) + PROBE_W'(stride);
  assign in_range = (probe < PROBE_W'(limit));
  assign word_sum = cfg.data_base_words + rd_data[2*WORD_W-1:WORD_W];

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ckbs_pkg::ST_IDLE: begin
        if (q_valid && q_data.lookup && !q_data.miss) state_next = ckbs_pkg::ST_PROBE;
      end
      ckbs_pkg::ST_PROBE: begin
        if (in_range) state_next = ckbs_pkg::ST_CMP;
        else if (sh == '0) state_next = ckbs_pkg::ST_FETCH;
      end
      ckbs_pkg::ST_CMP: begin
        state_next = (sh == '0) ? ckbs_pkg::ST_FETCH : ckbs_pkg::ST_PROBE;
      end
      ckbs_pkg::ST_FETCH: begin
        state_next = hit ? ckbs_pkg::ST_DONE : ckbs_pkg::ST_IDLE;
      end
      ckbs_pkg::ST_DONE: begin
        state_next = ckbs_pkg::ST_IDLE;
      end
      default: state_next = ckbs_pkg::ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    pop     = 1'b0;
    mem_wr  = 1'b0;
    key_rd  = 1'b0;
    data_rd = 1'b0;
    unique case (state)
      ckbs_pkg::ST_IDLE: begin
        pop    = q_valid;
        mem_wr = q_valid && !q_data.lookup;
      end
      ckbs_pkg::ST_PROBE: key_rd  = in_range;
      ckbs_pkg::ST_FETCH: data_rd = hit;
      ckbs_pkg::ST_CMP,
      ckbs_pkg::ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ckbs_pkg::ST_IDLE;
    else     state <= state_next;
  end

  // Result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == ckbs_pkg::ST_DONE) ||
              (state == ckbs_pkg::ST_FETCH && !hit) ||
              (state == ckbs_pkg::ST_IDLE && q_valid && q_data.lookup && q_data.miss);
    end
  end

  // Search datapath.
  always_ff @(posedge clk) begin
    unique case (state)
      ckbs_pkg::ST_IDLE: begin
        pos     <= '0;
        sh      <= cfg.search_steps;
        hit     <= 1'b0;
        hit_idx <= '0;
        skey    <= q_data.key;
        result  <= '0;
      end
      ckbs_pkg::ST_PROBE: begin
        if (in_range) probe_idx <= probe[IDX_W-1:0];
        else if (sh != '0) sh <= sh - 1'b1;
      end
      ckbs_pkg::ST_CMP: begin
        if (skey == rd_key) begin
          hit     <= 1'b1;
          hit_idx <= probe_idx;
        end else if (skey > rd_key) begin
          pos <= probe_idx;
        end
        if (sh != '0) sh <= sh - 1'b1;
      end
      ckbs_pkg::ST_FETCH: begin
        result <= '0;
      end
      ckbs_pkg::ST_DONE: begin
        result.found       <= 1'b1;
        result.match_index <= hit_idx;
        result.byte_offset <= word_sum << ckbs_pkg::BYTE_SHIFT;
        result.size_bytes  <= rd_data[WORD_W-1:0];
      end
      default: begin
      end
    endcase
  end

  // Key table: written by entry loads, read one probe at a time.
  always_ff @(posedge clk) begin
    if (mem_wr) keys[q_data.index] <= q_data.key;
    if (key_rd) rd_key <= keys[probe[IDX_W-1:0]];
  end

  // Offset and size table: read once for the matched entry.
  always_ff @(posedge clk) begin
    if (mem_wr)  entry_data[q_data.index] <= {q_data.offset, q_data.size};
    if (data_rd) rd_data <= entry_data[hit_idx];
  end

endmodule
`default_nettype wire

[hdl/ckbs_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "crc_keyed_table_binary_search_top_defines.svh"
module ckbs_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              done,
  input ckbs_pkg::result_t result
);

  // A miss carries all-zero fields.
  `CKBS_ASSERT_NOW(a_miss_zero, done && !result.found, result.match_index == '0 && result.byte_offset == '0 && result.size_bytes == '0)

  // A hit's byte offset is word aligned.
  `CKBS_ASSERT_NOW(a_hit_aligned, done && result.found, result.byte_offset[1:0] == 2'b00)

  // Busy rises only after a transaction is taken.
  `CKBS_ASSERT_NEXT(a_busy_cause, !start && !busy, !busy)

  // Reset leaves the block ready and quiet.
  `CKBS_ASSERT_RESET(a_reset_idle, !busy && !done)

endmodule

bind crc_keyed_table_binary_search_top ckbs_checker u_ckbs_checker (.*);
`default_nettype wire

[test/ckbs_search_scoreboard.sv]
`timescale 1ns / 1ps
// Watches the command, result and register ports of the keyed table search
// block, keeps its own copy of the table and registers, and scores every result.
module ckbs_search_scoreboard
  import ckbs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 busy,
  input  cmd_t                 cmd,
  input  logic                 done,
  input  result_t              result,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_data,
  output int                   mismatches,
  output int                   outstanding,
  output int                   lookups_seen,
  output int                   hits_seen
);

  logic              table_present;
  logic [CNT_W-1:0]  entry_count;
  logic [STEP_W-1:0] search_steps;
  logic [WORD_W-1:0] data_base;

  logic [WORD_W-1:0] key_mem  [TABLE_DEPTH];
  logic [WORD_W-1:0] off_mem  [TABLE_DEPTH];
  logic [WORD_W-1:0] size_mem [TABLE_DEPTH];

  result_t expected_results [$];
  int      results_seen;

  initial begin
    mismatches   = 0;
    outstanding  = 0;
    lookups_seen = 0;
    hits_seen    = 0;
    results_seen = 0;
  end

  task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                 input logic [WORD_W-1:0] want);
    mismatches++;
    $display("%0t: result %0d %s: got %h, want %h", $time, results_seen, what, got, want);
  endtask

  // Stride search from index 0, stride halving down to zero, probes kept
  // below the entry count clipped to the table depth.
  function automatic result_t search_table(input logic [WORD_W-1:0] key);
    result_t           r;
    int unsigned       limit;
    int unsigned       pos;
    int unsigned       stride;
    int unsigned       probe;
    logic [WORD_W-1:0] words;
    r     = '0;
    limit = (entry_count > TABLE_DEPTH) ? TABLE_DEPTH : entry_count;
    if (table_present && key != '0) begin
      pos    = 0;
      stride = 1 << search_steps;
      while (stride > 0) begin
        stride = stride >> 1;
        probe  = pos + stride;
        if (probe < limit) begin
          if (key == key_mem[probe]) begin
            r.found       = 1'b1;
            r.match_index = IDX_W'(probe);
          end else if (key > key_mem[probe]) begin
            pos = pos + stride;
          end
        end
      end
    end
    if (r.found) begin
      words         = data_base + off_mem[r.match_index];
      r.byte_offset = words << BYTE_SHIFT;
      r.size_bytes  = size_mem[r.match_index];
    end
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      table_present = 1'b0;
      entry_count   = '0;
      search_steps  = '0;
      data_base     = '0;
      expected_results.delete();
    end else begin
      if (done) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          report_mismatch("arrived with no lookup pending, found", result.found, '0);
        end else begin
          want = expected_results.pop_front();
          if (result.found !== want.found)
            report_mismatch("found", result.found, want.found);
          if (result.match_index !== want.match_index)
            report_mismatch("match_index", result.match_index, want.match_index);
          if (result.byte_offset !== want.byte_offset)
            report_mismatch("byte_offset", result.byte_offset, want.byte_offset);
          if (result.size_bytes !== want.size_bytes)
            report_mismatch("size_bytes", result.size_bytes, want.size_bytes);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_TABLE_PRESENT:   table_present = cfg_data[0];
          CFG_ENTRY_COUNT:     entry_count   = cfg_data[CNT_W-1:0];
          CFG_SEARCH_STEPS:    search_steps  = cfg_data[STEP_W-1:0];
          CFG_DATA_BASE_WORDS: data_base     = cfg_data;
          default: ;
        endcase
      end
      if (start && !busy) begin
        if (cmd.operation == OP_WRITE) begin
          key_mem[cmd.entry_index]  = cmd.key;
          off_mem[cmd.entry_index]  = cmd.entry_offset_words;
          size_mem[cmd.entry_index] = cmd.entry_size;
        end else begin
          want = search_table(cmd.key);
          expected_results.push_back(want);
          lookups_seen++;
          if (want.found) hits_seen++;
        end
      end
    end
    outstanding <= expected_results.size();
  end

endmodule

[test/tb_crc_keyed_table_binary_search_top.sv]
`timescale 1ns / 1ps
module tb_crc_keyed_table_binary_search_top;
  import ckbs_pkg::*;

  localparam int PHASES        = 11;
  localparam int RANDOM_ITEMS  = 37;
  // Settle time covers the longest (15-step) search plus the two-entry queue, rounded up.
  localparam int SETTLE_CYCLES = 64;
  localparam int DRAIN_LIMIT   = 4000;

  logic                 clk;
  logic                 rst       = 1'b1;
  logic                 start     = 1'b0;
  logic                 busy;
  cmd_t                 cmd       = '0;
  logic                 done;
  result_t              result;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_TABLE_PRESENT;
  logic [WORD_W-1:0]    cfg_data  = '0;

  int mismatches;
  int outstanding;
  int lookups_seen;
  int hits_seen;

  // Stimulus-side copy of the stored keys, so lookups can aim at real entries.
  logic [WORD_W-1:0] shadow_key [TABLE_DEPTH];
  int unsigned       loaded;   // slots 0..loaded-1 hold the current sorted table
  bit                gaps_on;
  int                sent;

  crc_keyed_table_binary_search_top u_top (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .done      (done),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  ckbs_search_scoreboard u_scoreboard (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .done         (done),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .outstanding  (outstanding),
    .lookups_seen (lookups_seen),
    .hits_seen    (hits_seen)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Present one transaction and hold it until the block takes it. Each cycle
  // before it, while gaps are on, drop start with a chance of 31 in a hundred.
  task automatic send_transaction(input cmd_t c);
    while (gaps_on && $urandom_range(99) < 31) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    cmd   <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent++;
  endtask

  // Load one table slot and mirror its key.
  task automatic write_entry(input int unsigned idx, input logic [WORD_W-1:0] k,
                             input logic [WORD_W-1:0] off, input logic [WORD_W-1:0] sz);
    cmd_t c;
    c.operation          = OP_WRITE;
    c.entry_index        = IDX_W'(idx);
    c.key                = k;
    c.entry_offset_words = off;
    c.entry_size         = sz;
    shadow_key[idx]      = k;
    send_transaction(c);
  endtask

  // Look up a key; the unused fields carry random bits.
  task automatic lookup_key(input logic [WORD_W-1:0] k);
    cmd_t c;
    c.operation          = OP_LOOKUP;
    c.entry_index        = IDX_W'($urandom);
    c.key                = k;
    c.entry_offset_words = $urandom;
    c.entry_size         = $urandom;
    send_transaction(c);
  endtask

  // Drop start, then wait for every lookup result and let the engine settle.
  task automatic wait_idle(input int settle);
    int guard;
    guard = 0;
    start <= 1'b0;
    @(posedge clk);
    while ((outstanding != 0 || busy) && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (settle) @(posedge clk);
  endtask

  // Hold cfg_we high across consecutive register writes; the caller lowers it.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [WORD_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic set_registers(input logic present, input int unsigned count,
                               input int unsigned steps, input logic [WORD_W-1:0] base);
    write_register(CFG_TABLE_PRESENT, WORD_W'(present));
    write_register(CFG_ENTRY_COUNT, WORD_W'(count));
    write_register(CFG_SEARCH_STEPS, WORD_W'(steps));
    write_register(CFG_DATA_BASE_WORDS, base);
    cfg_we <= 1'b0;
  endtask

  // Fill slots 0..n-1 with ascending keys; with dup set, some keys repeat.
  task automatic load_sorted_table(input int unsigned n, input bit dup);
    int unsigned k;
    int unsigned span;
    span = 32'hFFFF_F000 / (n + 1);
    k    = $urandom_range(span, 1);
    for (int unsigned i = 0; i < n; i++) begin
      write_entry(i, k, $urandom, $urandom);
      if (!(dup && $urandom_range(3) == 0)) k = k + $urandom_range(span, 1);
    end
    loaded = n;
  endtask

  initial begin
    int unsigned       n;
    int unsigned       count;
    int unsigned       steps;
    int unsigned       fit;
    int unsigned       roll;
    int unsigned       sel;
    int unsigned       slot;
    logic              present;
    logic              dup;
    logic              reload;
    logic [WORD_W-1:0] base;
    logic [WORD_W-1:0] k;

    gaps_on = 1'b1;
    sent    = 0;
    loaded  = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: registers still at reset, so the table counts as absent.
    lookup_key(32'h0000_0005);
    wait_idle(SETTLE_CYCLES);
    set_registers(1'b1, 8, 3, 32'h0000_0010);

    // Eight sorted entries: key 1 at the bottom, all-ones key at the top.
    // Slot 1 overflows the times-four step, slot 7 overflows base plus offset.
    write_entry(0, 32'h0000_0001, 32'h0000_0000, 32'h0000_0000);
    write_entry(1, 32'h0000_0010, 32'h4000_0000, 32'hFFFF_FFFF);
    write_entry(2, 32'h0000_0020, 32'h0000_0005, 32'h0000_0007);
    write_entry(3, 32'h0000_0030, 32'h0000_0100, 32'h0000_0040);
    write_entry(4, 32'h0000_0040, 32'h0001_0000, 32'h0000_1000);
    write_entry(5, 32'h0000_0050, 32'h8000_0000, 32'h0000_0001);
    write_entry(6, 32'h0000_0060, 32'h0000_00FF, 32'h0000_00FF);
    write_entry(7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_1234);
    loaded = 8;

    // Hits at both ends and inside, then a zero key and two misses.
    lookup_key(32'h0000_0001);
    lookup_key(32'h0000_0010);
    lookup_key(32'h0000_0040);
    lookup_key(32'h0000_0060);
    lookup_key(32'hFFFF_FFFF);
    lookup_key(32'h0000_0000);
    lookup_key(32'h0000_0015);
    lookup_key(32'hFFFF_FFFE);

    // Top slot with all-ones fields, outside the counted range.
    write_entry(TABLE_DEPTH - 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // Duplicate key in slots 2 and 3: the last equal probe wins.
    write_entry(3, 32'h0000_0020, 32'h0000_0009, 32'h0000_0009);
    lookup_key(32'h0000_0020);

    for (int p = 0; p < PHASES; p++) begin
      present = 1'b1;
      dup     = 1'b0;
      reload  = 1'b1;
      base    = $urandom;
      gaps_on = 1'b1;
      case (p)
        1:       n = 0;
        2:       n = 1;
        3:       n = $urandom_range(60, 25);
        4:       n = $urandom_range(40, 16);
        5:       n = $urandom_range(30, 10);
        6:       n = 12;
        7:       n = 30;
        8:       n = $urandom_range(20, 5);
        9:       n = $urandom_range(32, 16);
        10:      n = loaded;
        default: n = $urandom_range(24, 8);
      endcase
      fit = 0;
      while ((1 << fit) < n) fit++;
      count = n;
      steps = fit;
      case (p)
        4:  steps = (fit > 2) ? fit - 2 : 0;   // search too short to reach the top
        5:  steps = 15;
        6:  present = 1'b0;
        7:  dup = 1'b1;
        8: begin
          base    = 32'hFFFF_FFFF;
          gaps_on = 1'b0;                      // long stretch with start held high
        end
        9: begin
          count = 2047;                        // count past the depth gets clipped
          steps = ((1 << fit) > n) ? fit - 1 : fit;  // probes stay below n
        end
        10: begin
          base   = 32'h0000_0000;
          steps  = 15;
          reload = 1'b0;                       // keep the table from the last phase
        end
        default: ;
      endcase

      wait_idle(SETTLE_CYCLES);
      set_registers(present, count, steps, base);
      if (reload) load_sorted_table(n, dup);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
        // Once, drain every result mid-stream before sending on.
        if (p == 3 && i == RANDOM_ITEMS / 2) wait_idle(0);
        roll = $urandom_range(99);
        if (roll < 70) begin
          // Mostly keys that are in the table, then neighbors, random, zero.
          sel = $urandom_range(99);
          if (loaded != 0 && sel < 55)
            k = shadow_key[$urandom_range(loaded - 1)];
          else if (loaded != 0 && sel < 65)
            k = shadow_key[$urandom_range(loaded - 1)] + 32'd1;
          else if (loaded != 0 && sel < 75)
            k = shadow_key[$urandom_range(loaded - 1)] - 32'd1;
          else if (sel < 90)
            k = $urandom;
          else
            k = '0;
          lookup_key(k);
        end else if (roll < 85 || loaded == 0) begin
          // Noise outside the searched range, or anywhere once the table is full.
          slot = (loaded < TABLE_DEPTH) ? $urandom_range(TABLE_DEPTH - 1, loaded)
                                        : $urandom_range(TABLE_DEPTH - 1);
          write_entry(slot, $urandom, $urandom, $urandom);
        end else begin
          // Rewrite a live slot: same key with a new payload, or break the order.
          slot = $urandom_range(loaded - 1);
          k    = ($urandom_range(99) < 60) ? shadow_key[slot] : $urandom;
          write_entry(slot, k, $urandom, $urandom);
        end
      end
    end

    wait_idle(SETTLE_CYCLES);

    $display("Sent %0d transactions over %0d register setups: %0d lookups, %0d hits.",
             sent, PHASES + 2, lookups_seen, hits_seen);
    $display("Setups spanned an absent table, empty and small tables, short and 15-step");
    $display("searches, duplicate keys, offset wraparound and a count past the depth.");
    if (outstanding != 0) $display("%0d lookup results never arrived", outstanding);
    if (mismatches == 0 && outstanding == 0) begin
      $display("** crc_keyed_table_binary_search_top: PASSED **");
    end else begin
      $display("** crc_keyed_table_binary_search_top: FAILED **");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #3_000_000;
    $display("Run limit reached with %0d results still due", outstanding);
    $display("** crc_keyed_table_binary_search_top: FAILED **");
    $finish;
  end

endmodule

[sim.f]
+incdir+hdl
hdl/ckbs_pkg.sv
hdl/ckbs_front.sv
hdl/ckbs_queue.sv
hdl/ckbs_back.sv
hdl/crc_keyed_table_binary_search_top.sv
hdl/ckbs_checker.sv
test/ckbs_search_scoreboard.sv
test/tb_crc_keyed_table_binary_search_top.sv
